@@ rtl/point_rotate_x_then_y_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the point rotation block
// Concurrent checks on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef POINT_ROTATE_X_THEN_Y_TOP_ASSERT_SVH
`define POINT_ROTATE_X_THEN_Y_TOP_ASSERT_SVH

// same-cycle implication
`define PRX_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/prx_pkg.sv @@
// ----------------------------------------------------------------------------
// prx_pkg
// Shared constants, series coefficients and bundle types for the rotator.
// ----------------------------------------------------------------------------
package prx_pkg;

  // default field widths
  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_ANGLE_WIDTH = 16;

  // Q30 fixed point for sine and cosine
  localparam int              FRAC_BITS = 30;
  localparam logic [30:0]     ONE_Q30   = 31'h4000_0000;
  localparam logic [63:0]     HALF_Q30  = 64'h0000_0000_2000_0000;
  localparam logic [63:0]     HALF_Q32  = 64'h0000_0000_8000_0000;
  // round(pi * 2^31)
  localparam logic [32:0]     PI_Q31    = 33'd6746518852;

  // Horner divisors of the sine and cosine series
  localparam int              HORNER_STEPS = 6;
  localparam int unsigned     SIN_DEN [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned     COS_DEN [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12};

  // pipeline depths
  localparam int STEP_LAT = 3;
  localparam int TRIG_LAT = 2 + HORNER_STEPS * STEP_LAT + 2;
  localparam int MIX_LAT  = 2;

  // quadrant of a binary angle
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // word passed between series steps
  typedef struct packed {
    logic [31:0] t2;  // theta squared, Q30
    logic [30:0] ps;  // sine partial, Q30
    logic [30:0] pc;  // cosine partial, Q30
    logic [30:0] th;  // residual angle in radians, Q30
    quad_t       q;
  } horner_t;

  // cosine and sine of one angle with their negations, Q30
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [31:0] nc;
    logic signed [31:0] ns;
  } trig_t;

endpackage

@@ rtl/prx_delay.sv @@
// ----------------------------------------------------------------------------
// prx_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module prx_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[DEPTH-1];

endmodule

@@ rtl/prx_step.sv @@
// ----------------------------------------------------------------------------
// prx_step
// One Horner step of the sine and cosine series: p = 1 - (t2 * p) / n.
// Three stages: product, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module prx_step import prx_pkg::*; #(
  parameter int unsigned NS = 6,
  parameter int unsigned NC = 12
) (
  input  logic    clk,
  input  logic    en,
  input  horner_t din,
  output horner_t dout
);

  // floor(2^32 / n): quotient estimate is low by at most one
  localparam logic [31:0] MS = 32'((64'd1 << 32) / 64'(NS));
  localparam logic [31:0] MC = 32'((64'd1 << 32) / 64'(NC));

  horner_t     a_h, b_h, h_next;
  logic [31:0] a_xs, a_xc;
  logic [31:0] b_xs, b_xc, b_qs, b_qc;
  logic [31:0] rs, rc, qs, qc;

  // stage A: (t2 * p) >> 30
  always_ff @(posedge clk) begin
    if (en) begin
      a_h  <= din;
      a_xs <= 32'((64'(din.t2) * 64'(din.ps)) >> FRAC_BITS);
      a_xc <= 32'((64'(din.t2) * 64'(din.pc)) >> FRAC_BITS);
    end
  end

  // stage B: quotient estimate by reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      b_h  <= a_h;
      b_xs <= a_xs;
      b_xc <= a_xc;
      b_qs <= 32'((64'(a_xs) * 64'(MS)) >> 32);
      b_qc <= 32'((64'(a_xc) * 64'(MC)) >> 32);
    end
  end

  // stage C: fix the quotient, next partial
  always_comb begin
    rs = b_xs - b_qs * 32'(NS);
    rc = b_xc - b_qc * 32'(NC);
    qs = b_qs + 32'(rs >= 32'(NS));
    qc = b_qc + 32'(rc >= 32'(NC));
    h_next    = b_h;
    h_next.ps = ONE_Q30 - 31'(qs);
    h_next.pc = ONE_Q30 - 31'(qc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= h_next;
    end
  end

endmodule

@@ rtl/prx_trig.sv @@
// ----------------------------------------------------------------------------
// prx_trig
// Pipelined sine and cosine of a binary angle in Q30, quadrant mapped.
// Residual to radians, square, six series steps, finish and quadrant.
// ----------------------------------------------------------------------------
module prx_trig import prx_pkg::*; #(
  parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output trig_t                  cs_out
);

  localparam int RES_W = ANGLE_WIDTH - 2;
  localparam int RK_W  = RES_W + 33;
  localparam int ALIGN = 32 - ANGLE_WIDTH;

  logic [RK_W-1:0] rk;
  logic [30:0]     th1;
  quad_t           q1;
  logic [63:0]     sq;
  horner_t         h0;
  horner_t         chain [HORNER_STEPS+1];
  horner_t         hl;
  logic [30:0]     f_sraw;
  logic [31:0]     f_hx;
  quad_t           f_q;
  logic [30:0]     sn, h, cs;
  logic signed [31:0] sn_s, cs_s;
  trig_t           t_next;

  // residual angle to radians
  assign rk = RK_W'(angle[RES_W-1:0]) * RK_W'(PI_Q31);

  always_ff @(posedge clk) begin
    if (en) begin
      th1 <= 31'(((64'(rk) << ALIGN) + HALF_Q32) >> 32);
      q1  <= quad_t'(angle[ANGLE_WIDTH-1 -: 2]);
    end
  end

  // theta squared, series seeds
  assign sq = 64'(th1) * 64'(th1);

  always_ff @(posedge clk) begin
    if (en) begin
      h0.t2 <= 32'((sq + HALF_Q30) >> FRAC_BITS);
      h0.ps <= ONE_Q30;
      h0.pc <= ONE_Q30;
      h0.th <= th1;
      h0.q  <= q1;
    end
  end

  assign chain[0] = h0;

  // series steps
  for (genvar gi = 0; gi < HORNER_STEPS; gi++) begin : g_step
    prx_step #(
      .NS (SIN_DEN[gi]),
      .NC (COS_DEN[gi])
    ) u_step (
      .clk  (clk),
      .en   (en),
      .din  (chain[gi]),
      .dout (chain[gi+1])
    );
  end

  assign hl = chain[HORNER_STEPS];

  // finish: sin = theta * p, cos term = t2 * p
  always_ff @(posedge clk) begin
    if (en) begin
      f_sraw <= 31'((64'(hl.th) * 64'(hl.ps) + HALF_Q30) >> FRAC_BITS);
      f_hx   <= 32'((64'(hl.t2) * 64'(hl.pc)) >> FRAC_BITS);
      f_q    <= hl.q;
    end
  end

  // clamp and quadrant mapping
  always_comb begin
    sn   = (f_sraw > ONE_Q30) ? ONE_Q30 : f_sraw;
    h    = f_hx[31:1];
    cs   = (h >= ONE_Q30) ? '0 : ONE_Q30 - h;
    sn_s = signed'({1'b0, sn});
    cs_s = signed'({1'b0, cs});
    case (f_q)
      QUAD_0: begin
        t_next.c = cs_s;
        t_next.s = sn_s;
      end
      QUAD_1: begin
        t_next.c = -sn_s;
        t_next.s = cs_s;
      end
      QUAD_2: begin
        t_next.c = -cs_s;
        t_next.s = -sn_s;
      end
      default: begin
        // fourth quadrant
        t_next.c = sn_s;
        t_next.s = -cs_s;
      end
    endcase
    t_next.nc = -t_next.c;
    t_next.ns = -t_next.s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_out <= t_next;
    end
  end

endmodule

@@ rtl/prx_mix.sv @@
// ----------------------------------------------------------------------------
// prx_mix
// Rotation component r = round_half_up((a*c - b*d) / 2^30).
// Stage 1 forms split partial products, stage 2 sums and rounds.
// ----------------------------------------------------------------------------
module prx_mix import prx_pkg::*; #(
  parameter int AW = 32,
  parameter int OW = 34
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [AW-1:0] b,
  input  logic signed [31:0]   c,
  input  logic signed [31:0]   d,
  output logic signed [OW-1:0] r
);

  localparam int LO_W = 24;
  localparam int AE   = (AW > LO_W + 2) ? AW : LO_W + 2;
  localparam int HI_W = AE - LO_W;
  localparam int PL_W = LO_W + 1 + 32;
  localparam int PH_W = HI_W + 32;
  localparam int SW   = AE + 34;
  localparam logic signed [SW-1:0] RND = SW'(HALF_Q30);

  logic signed [AE-1:0]   a_ext, b_ext;
  logic signed [LO_W:0]   al, bl;
  logic signed [HI_W-1:0] ah, bh;
  logic signed [PL_W-1:0] pl_a, pl_b;
  logic signed [PH_W-1:0] ph_a, ph_b;
  logic signed [SW-1:0]   hi, lo, sum;

  // split operands into an unsigned low part and a signed high part
  assign a_ext = AE'(a);
  assign b_ext = AE'(b);
  assign al    = signed'({1'b0, a_ext[LO_W-1:0]});
  assign bl    = signed'({1'b0, b_ext[LO_W-1:0]});
  assign ah    = a_ext[AE-1:LO_W];
  assign bh    = b_ext[AE-1:LO_W];

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pl_a <= al * c;
      pl_b <= bl * d;
      ph_a <= ah * c;
      ph_b <= bh * d;
    end
  end

  // stage 2: exact sum, round half up
  assign hi  = SW'(ph_a) - SW'(ph_b);
  assign lo  = SW'(pl_a) - SW'(pl_b) + RND;
  assign sum = (hi <<< LO_W) + lo;

  always_ff @(posedge clk) begin
    if (en) begin
      r <= OW'(sum >>> FRAC_BITS);
    end
  end

endmodule

@@ rtl/point_rotate_x_then_y_top.sv @@
// ----------------------------------------------------------------------------
// point_rotate_x_then_y_top: one word per cycle while the output buffer has room.
// Words pass through the sine/cosine pipeline (six series steps, three stages each) and
// the two rotation stages; a two-word output buffer stalls the pipeline only when full.
// rst (synchronous) clears the valid chain and the output buffer; data is not reset.
// ----------------------------------------------------------------------------
`include "point_rotate_x_then_y_top_assert.svh"

module point_rotate_x_then_y_top import prx_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic [ANGLE_WIDTH-1:0]        angle_x,
  input  logic [ANGLE_WIDTH-1:0]        angle_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          saturated
);

  localparam int W         = COORD_WIDTH;
  localparam int OW        = W + 2;
  localparam int LAT       = TRIG_LAT + 2 * MIX_LAT;
  localparam int EW        = 3 * W + 1;
  localparam int BUF_DEPTH = 2;
  localparam int TW        = $bits(trig_t);
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  logic               en;
  trig_t              tx, ty, ty_d;
  logic [TW-1:0]      ty_bits;
  logic [W-1:0]       xd, yd, zd;
  logic signed [OW-1:0] x_wide, y1, z1, x2, z2;
  logic [OW-1:0]      y1_bits;
  logic [LAT-1:0]     vld;
  logic [W:0]         cx, cy, cz;
  logic [EW-1:0]      ent_next, e0, e1;
  logic [1:0]         fill, fill_next;
  logic               push, pop;
  logic               rail_hit;

  // saturate a wide component; top bit of the result flags a clip
  function automatic logic [W:0] clip(input logic signed [OW-1:0] v);
    logic         ovf;
    logic [W-1:0] val;
    ovf = !((&v[OW-1:W-1]) || !(|v[OW-1:W-1]));
    val = ovf ? (v[OW-1] ? MIN_V : MAX_V) : v[W-1:0];
    return {ovf, val};
  endfunction

  // pipeline advances while the output buffer has room
  assign en       = (fill != 2'(BUF_DEPTH));
  assign in_ready = en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // sine and cosine of both angles
  prx_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_x (
    .clk    (clk),
    .en     (en),
    .angle  (angle_x),
    .cs_out (tx)
  );

  prx_trig #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_y (
    .clk    (clk),
    .en     (en),
    .angle  (angle_y),
    .cs_out (ty)
  );

  // coordinate alignment
  prx_delay #(.WIDTH(W), .DEPTH(TRIG_LAT)) u_dly_y (
    .clk (clk), .en (en), .din (in_y), .dout (yd)
  );

  prx_delay #(.WIDTH(W), .DEPTH(TRIG_LAT)) u_dly_z (
    .clk (clk), .en (en), .din (in_z), .dout (zd)
  );

  prx_delay #(.WIDTH(W), .DEPTH(TRIG_LAT + MIX_LAT)) u_dly_x (
    .clk (clk), .en (en), .din (in_x), .dout (xd)
  );

  prx_delay #(.WIDTH(TW), .DEPTH(MIX_LAT)) u_dly_ty (
    .clk (clk), .en (en), .din (ty), .dout (ty_bits)
  );

  assign ty_d = trig_t'(ty_bits);

  // rotation in the Y-Z plane
  prx_mix #(.AW(W), .OW(OW)) u_mix_y1 (
    .clk (clk), .en (en), .a (signed'(yd)), .b (signed'(zd)),
    .c (tx.c), .d (tx.s), .r (y1)
  );

  prx_mix #(.AW(W), .OW(OW)) u_mix_z1 (
    .clk (clk), .en (en), .a (signed'(yd)), .b (signed'(zd)),
    .c (tx.s), .d (tx.nc), .r (z1)
  );

  // rotation in the X-Z plane
  assign x_wide = OW'(signed'(xd));

  prx_mix #(.AW(OW), .OW(OW)) u_mix_x2 (
    .clk (clk), .en (en), .a (x_wide), .b (z1),
    .c (ty_d.c), .d (ty_d.ns), .r (x2)
  );

  prx_mix #(.AW(OW), .OW(OW)) u_mix_z2 (
    .clk (clk), .en (en), .a (z1), .b (x_wide),
    .c (ty_d.c), .d (ty_d.s), .r (z2)
  );

  prx_delay #(.WIDTH(OW), .DEPTH(MIX_LAT)) u_dly_y1 (
    .clk (clk), .en (en), .din (y1), .dout (y1_bits)
  );

  // saturation and word assembly
  always_comb begin
    cx       = clip(x2);
    cy       = clip(signed'(y1_bits));
    cz       = clip(z2);
    ent_next = {cx[W-1:0], cy[W-1:0], cz[W-1:0], cx[W] | cy[W] | cz[W]};
  end

  // two-word output buffer
  assign push      = en && vld[LAT-1];
  assign pop       = out_valid && out_ready;
  assign fill_next = fill + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (fill == 2'(BUF_DEPTH)) begin
        e0 <= e1;
      end else begin
        e0 <= ent_next;
      end
    end else if (push) begin
      if (fill == '0) begin
        e0 <= ent_next;
      end else begin
        e1 <= ent_next;
      end
    end
  end

  assign out_valid = (fill != '0);
  assign out_x     = signed'(e0[EW-1 -: W]);
  assign out_y     = signed'(e0[EW-1-W -: W]);
  assign out_z     = signed'(e0[EW-1-2*W -: W]);
  assign saturated = e0[0];

  // any output sitting on a rail
  assign rail_hit = (out_x == MAX_V) || (out_x == MIN_V) ||
                    (out_y == MAX_V) || (out_y == MIN_V) ||
                    (out_z == MAX_V) || (out_z == MIN_V);

  // checks
  `PRX_ASSERT_IMPLY(a_fill_bound, 1'b1, fill <= 2'(BUF_DEPTH), "output buffer overfilled")
  `PRX_ASSERT_NEXT(a_stall_freeze, !in_ready, $stable(vld), "valid chain moved in a stall")
  `PRX_ASSERT_IMPLY(a_sat_rail, out_valid && saturated, rail_hit, "clip flag with no railed output")

endmodule

@@ sim/tb_point_rotate_x_then_y_top.sv @@
// ----------------------------------------------------------------------------
// tb_point_rotate_x_then_y_top
// Self-checking bench for the two-stage point rotator: every accepted word is
// rotated in the Y-Z plane by angle_x and then in the X-Z plane by angle_y.
// The expected point comes from a bit-exact fixed-point model held by a
// scoreboard object. Directed corners run first, then random points with
// random gaps on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_rotate_x_then_y_top import prx_pkg::*;;

  localparam int CW             = 32;
  localparam int AW             = 16;
  localparam int RANDOM_POINTS  = 1050;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;

  // one rotated point as seen on the output side
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 sat;
  } rotated_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each rotated point and checks results in order
  // --------------------------------------------------------------------------
  class point_rotation_checker;
    rotated_t expected_points[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // sine/cosine of a binary angle, Q30, quadrant folded in
    function void angle_trig(input logic [AW-1:0] ang,
                             output logic signed [95:0] c,
                             output logic signed [95:0] s);
      bit [63:0]   turn, resid, th, t2, p, sn, cs, h;
      quad_t       quad;
      int unsigned sin_div[6];
      int unsigned cos_div[6];
      sin_div = '{156, 110, 72, 42, 20, 6};
      cos_div = '{182, 132, 90, 56, 30, 12};
      turn  = 64'(ang) << (32 - AW);
      quad  = quad_t'(turn[31:30]);
      resid = {34'd0, turn[29:0]};
      // residual in radians: round(resid * pi * 2^31 / 2^32)
      th = (resid * 64'd6746518852 + 64'h8000_0000) >> 32;
      t2 = (th * th + 64'h2000_0000) >> 30;
      // Horner series for sine
      p = 64'h4000_0000;
      for (int i = 0; i < 6; i++)
        p = 64'h4000_0000 - ((t2 * p) >> 30) / 64'(sin_div[i]);
      sn = (th * p + 64'h2000_0000) >> 30;
      if (sn > 64'h4000_0000) sn = 64'h4000_0000;
      // Horner series for cosine
      p = 64'h4000_0000;
      for (int i = 0; i < 6; i++)
        p = 64'h4000_0000 - ((t2 * p) >> 30) / 64'(cos_div[i]);
      h  = ((t2 * p) >> 30) / 64'd2;
      cs = (h >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - h;
      case (quad)
        QUAD_0: begin c =  $signed({32'd0, cs}); s =  $signed({32'd0, sn}); end
        QUAD_1: begin c = -$signed({32'd0, sn}); s =  $signed({32'd0, cs}); end
        QUAD_2: begin c = -$signed({32'd0, cs}); s = -$signed({32'd0, sn}); end
        default: begin c = $signed({32'd0, sn}); s = -$signed({32'd0, cs}); end
      endcase
    endfunction

    // a*c - b*d rounded half up from Q30, exact in between
    function logic signed [95:0] rot_term(input logic signed [95:0] a, b, c, d);
      logic signed [95:0] acc;
      acc = a * c - b * d + 96'sh2000_0000;
      return acc >>> 30;
    endfunction

    function logic signed [CW-1:0] clamp(input logic signed [95:0] v, inout logic flag);
      logic signed [95:0] hi, lo;
      hi = 96'sh7FFF_FFFF;
      lo = -hi - 96'sd1;
      if (v > hi) begin flag = 1'b1; return hi[CW-1:0]; end
      if (v < lo) begin flag = 1'b1; return lo[CW-1:0]; end
      return v[CW-1:0];
    endfunction

    function rotated_t rotate_point(input logic signed [CW-1:0] px, py, pz,
                                    input logic [AW-1:0] ax, ay);
      logic signed [95:0] x, y, z, ca, sa, cb, sb, y1, z1, x2, z2;
      rotated_t           r;
      logic               flag;
      x = 96'(px);
      y = 96'(py);
      z = 96'(pz);
      flag = 1'b0;
      angle_trig(ax, ca, sa);
      angle_trig(ay, cb, sb);
      // Y-Z plane first, intermediates kept exact
      y1 = rot_term(y, z, ca, sa);
      z1 = rot_term(y, z, sa, -ca);
      // then X-Z plane
      x2 = rot_term(x, z1, cb, -sb);
      z2 = rot_term(z1, x, cb, sb);
      r.x   = clamp(x2, flag);
      r.y   = clamp(y1, flag);
      r.z   = clamp(z2, flag);
      r.sat = flag;
      return r;
    endfunction

    function void note_point(input logic signed [CW-1:0] px, py, pz,
                             input logic [AW-1:0] ax, ay);
      expected_points.push_back(rotate_point(px, py, pz, ax, ay));
    endfunction

    function void check_rotated(input rotated_t got);
      rotated_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected word x=%h y=%h z=%h sat=%b",
                   got.x, got.y, got.z, got.sat);
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: exp x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                   want.x, want.y, want.z, want.sat,
                   got.x, got.y, got.z, got.sat);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  logic signed [CW-1:0] in_z;
  logic [AW-1:0]        angle_x;
  logic [AW-1:0]        angle_y;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 saturated;

  point_rotate_x_then_y_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .saturated (saturated)
  );

  point_rotation_checker sb;
  logic no_idle;
  int   stall_left;
  int   idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output back-pressure, off while no_idle is set
  always @(negedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_point(in_x, in_y, in_z, angle_x, angle_y);
      if (out_valid && out_ready)
        sb.check_rotated('{x: out_x, y: out_y, z: out_z, sat: saturated});
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_point_rotate_x_then_y_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one word, hold it until taken, then maybe leave a gap
  task automatic send_point(input logic signed [CW-1:0] px, py, pz,
                            input logic [AW-1:0] ax, ay);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_x     <= px;
    in_y     <= py;
    in_z     <= pz;
    angle_x  <= ax;
    angle_y  <= ay;
    do @(posedge clk); while (!in_ready);
    gap = (no_idle || $urandom_range(0, 99) < 40) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    int                   kind;
    kind = $urandom_range(0, 6);
    case (kind)
      0, 1: v = $urandom;
      2: begin
        v = $urandom_range(0, 32'h001F_FFFF);
        v = v - 32'sh0010_0000;
      end
      3: begin
        v = $urandom_range(0, 255);
        v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - v : 32'sh8000_0000 + v;
      end
      4: begin
        v = $urandom_range(0, 2);
        v = v - 32'sd1;
      end
      default: begin
        v = $urandom_range(0, 32'h1FFF_FFFF);
        v = v - 32'sh1000_0000;
      end
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    logic [AW-1:0] a;
    logic [AW-1:0] d;
    int            kind;
    kind = $urandom_range(0, 4);
    case (kind)
      0, 1, 2: a = 16'($urandom);
      3: begin
        // near a quadrant boundary, wrapping through zero
        a = 16'(16384 * $urandom_range(0, 3));
        d = 16'($urandom_range(0, 6));
        a = a + d - 16'd3;
      end
      default: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [CW-1:0] rx, ry, rz;
    logic [AW-1:0]        ra, rb;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_x        = '0;
    in_y        = '0;
    in_z        = '0;
    angle_x     = '0;
    angle_y     = '0;
    out_ready   = 1'b0;
    no_idle     = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners: origin, unit axes, extremes, saturation, angle wraps
    send_point(32'sd0, 32'sd0, 32'sd0, 16'd0, 16'd0);
    send_point(32'sh0001_0000, 32'sd0, 32'sd0, 16'd16384, 16'd0);
    send_point(32'sd0, 32'sh0001_0000, 32'sd0, 16'd16384, 16'd16384);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd0, 16'd0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'd0, 16'd0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'd32768, 16'd0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd8192, 16'd8192);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd24576, 16'd57344);
    send_point(32'sd0, 32'sd0, 32'sd0, 16'hFFFF, 16'hFFFF);
    send_point(32'sd1, -32'sd1, 32'sd1, 16'd1, 16'hFFFF);
    send_point(-32'sd1, -32'sd1, -32'sd1, 16'd49152, 16'd32768);
    send_point(32'sh7FFF_FFFF, 32'sd0, 32'sd0, 16'd0, 16'd16384);
    send_point(32'sd0, 32'sd0, 32'sh8000_0000, 16'd16384, 16'd49152);
    send_point(32'sd12345678, -32'sd87654321, 32'sd55555555, 16'd12345, 16'd54321);
    send_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 16'h5555, 16'hAAAA);
    send_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 16'hAAAA, 16'h5555);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'd16383, 16'd16385);
    send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 16'd32767, 16'd32769);
    send_point(32'sh4000_0000, 32'sh4000_0000, -32'sh4000_0000, 16'd49151, 16'd49153);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'd0, 16'd32768);

    // random points, with one stretch of back-to-back traffic
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      no_idle = (n >= 300 && n < 450);
      rx = rand_coord();
      ry = rand_coord();
      rz = rand_coord();
      ra = rand_angle();
      rb = rand_angle();
      send_point(rx, ry, rz, ra, rb);
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give stray words a chance to show up
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_point_rotate_x_then_y_top: PASS");
    end else begin
      $display("tb_point_rotate_x_then_y_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/prx_pkg.sv
rtl/prx_delay.sv
rtl/prx_step.sv
rtl/prx_trig.sv
rtl/prx_mix.sv
rtl/point_rotate_x_then_y_top.sv
sim/tb_point_rotate_x_then_y_top.sv
